[hw/rtl/vvp_pkg.sv]
// Shared constants, register codes and pipeline flag types for the vertex projection block.
`timescale 1ns / 1ps

package vvp_pkg;

  // Rotation coefficients: signed Q2.14, three to a 48-bit row.
  localparam int ROT_COEF_W = 16;
  localparam int ROT_FRAC   = 14;
  localparam int ROW_W      = 3 * ROT_COEF_W;

  localparam logic [ROW_W-1:0] ROT_RESET_X = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROT_RESET_Y = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROT_RESET_Z = 48'h4000_0000_0000;

  // Eye coordinates carry this many bits above the coordinate width.
  localparam int EYE_EXTRA = 5;

  // Low slice width for the split numerator multiply.
  localparam int PP_SPLIT = 16;

  // Quotient bits resolved per divider stage.
  localparam int DIV_STEPS = 2;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_ROW_X = 3'd0,
    CFG_ROT_ROW_Y = 3'd1,
    CFG_ROT_ROW_Z = 3'd2,
    CFG_EYE_POS_X = 3'd3,
    CFG_EYE_POS_Y = 3'd4,
    CFG_EYE_POS_Z = 3'd5,
    CFG_PROJ_DIST = 3'd6
  } vvp_cfg_idx_t;

  // Per-vertex side information that rides along with the divider.
  typedef struct packed {
    logic zero_depth;  // eye z rounded to zero
    logic neg_x;       // sign of xe/ze quotient
    logic neg_y;
    logic ovf_x;       // quotient beyond coordinate range
    logic ovf_y;
    logic xe_pos;
    logic xe_neg;
    logic ye_pos;
    logic ye_neg;
  } vvp_flags_t;

endpackage

[hw/rtl/vvp_eye_xform.sv]
// Eye offset, 3x3 view rotation and rounding to eye-space coordinates (three stages).
`timescale 1ns / 1ps

module vvp_eye_xform #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               en,
  input  logic                                               in_valid,
  input  logic signed [COORD_WIDTH-1:0]                      pt_x,
  input  logic signed [COORD_WIDTH-1:0]                      pt_y,
  input  logic signed [COORD_WIDTH-1:0]                      pt_z,
  input  logic signed [COORD_WIDTH-1:0]                      eye_x,
  input  logic signed [COORD_WIDTH-1:0]                      eye_y,
  input  logic signed [COORD_WIDTH-1:0]                      eye_z,
  input  logic [vvp_pkg::ROW_W-1:0]                          row_x,
  input  logic [vvp_pkg::ROW_W-1:0]                          row_y,
  input  logic [vvp_pkg::ROW_W-1:0]                          row_z,
  output logic                                               out_valid,
  output logic signed [COORD_WIDTH+vvp_pkg::EYE_EXTRA-1:0]   xe,
  output logic signed [COORD_WIDTH+vvp_pkg::EYE_EXTRA-1:0]   ye,
  output logic signed [COORD_WIDTH+vvp_pkg::EYE_EXTRA-1:0]   ze
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int CW = vvp_pkg::ROT_COEF_W;
  localparam int PW = DW + CW;
  localparam int SW = PW + 2;
  localparam int EW = W + vvp_pkg::EYE_EXTRA;
  localparam logic signed [SW-1:0] RND = SW'(1 << (vvp_pkg::ROT_FRAC - 1));

  logic signed [W-1:0]        pt  [3];
  logic signed [W-1:0]        eye [3];
  logic [vvp_pkg::ROW_W-1:0]  row [3];

  logic signed [DW-1:0] d_r   [3];
  logic signed [DW-1:0] d_nxt [3];
  logic signed [PW-1:0] p_r   [3][3];
  logic signed [PW-1:0] p_nxt [3][3];
  logic signed [SW-1:0] sum   [3];
  logic signed [EW-1:0] e_r   [3];
  logic signed [EW-1:0] e_nxt [3];
  logic                 d_vld_r;
  logic                 p_vld_r;
  logic                 e_vld_r;

  assign pt[0]  = pt_x;
  assign pt[1]  = pt_y;
  assign pt[2]  = pt_z;
  assign eye[0] = eye_x;
  assign eye[1] = eye_y;
  assign eye[2] = eye_z;
  assign row[0] = row_x;
  assign row[1] = row_y;
  assign row[2] = row_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = DW'(pt[i]) - DW'(eye[i]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        p_nxt[i][k] = PW'(signed'(row[i][CW*k +: CW])) * PW'(d_r[k]);
      end
    end
    // floor((s + half) / 2^14): round to nearest, ties upward
    for (int i = 0; i < 3; i++) begin
      sum[i]   = SW'(p_r[i][0]) + SW'(p_r[i][1]) + SW'(p_r[i][2]) + RND;
      e_nxt[i] = sum[i][SW-1:vvp_pkg::ROT_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      p_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= in_valid;
      p_vld_r <= d_vld_r;
      e_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
      p_r <= p_nxt;
      e_r <= e_nxt;
    end
  end

  assign out_valid = e_vld_r;
  assign xe        = e_r[0];
  assign ye        = e_r[1];
  assign ze        = e_r[2];

endmodule

[hw/rtl/vvp_proj_setup.sv]
// Magnitudes, depth saturation, split numerator multiply and range check (three stages).
`timescale 1ns / 1ps

module vvp_proj_setup #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 en,
  input  logic                                                 in_valid,
  input  logic signed [COORD_WIDTH+vvp_pkg::EYE_EXTRA-1:0]     xe,
  input  logic signed [COORD_WIDTH+vvp_pkg::EYE_EXTRA-1:0]     ye,
  input  logic signed [COORD_WIDTH+vvp_pkg::EYE_EXTRA-1:0]     ze,
  input  logic [COORD_WIDTH-1:0]                               h,
  output logic                                                 out_valid,
  output vvp_pkg::vvp_flags_t                                  out_flags,
  output logic [2*COORD_WIDTH+vvp_pkg::EYE_EXTRA-1:0]          num_x,
  output logic [2*COORD_WIDTH+vvp_pkg::EYE_EXTRA-1:0]          num_y,
  output logic [COORD_WIDTH+vvp_pkg::EYE_EXTRA-1:0]            den,
  output logic [COORD_WIDTH-1:0]                               depth
);

  localparam int W   = COORD_WIDTH;
  localparam int EW  = W + vvp_pkg::EYE_EXTRA;
  localparam int NW  = EW + W;
  localparam int LO  = vvp_pkg::PP_SPLIT;
  localparam int LW  = LO + W;
  localparam int HW  = EW - LO + W;
  localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

  // stage A: magnitudes and flags
  logic [EW-1:0]        ax_r, ay_r, az_r;
  logic [EW-1:0]        ax_nxt, ay_nxt, az_nxt;
  vvp_pkg::vvp_flags_t  a_flags_r, a_flags_nxt;
  logic [W-1:0]         a_depth_r, a_depth_nxt;
  logic                 a_vld_r;

  // stage B: partial products
  logic [LW-1:0]        plo_x_r, plo_y_r, plo_x_nxt, plo_y_nxt;
  logic [HW-1:0]        phi_x_r, phi_y_r, phi_x_nxt, phi_y_nxt;
  logic [EW-1:0]        b_az_r;
  vvp_pkg::vvp_flags_t  b_flags_r;
  logic [W-1:0]         b_depth_r;
  logic                 b_vld_r;

  // stage C: full numerators
  logic [NW-1:0]        nx_nxt, ny_nxt, nx_r, ny_r;
  logic [EW-1:0]        c_az_r;
  vvp_pkg::vvp_flags_t  c_flags_r, c_flags_nxt;
  logic [W-1:0]         c_depth_r;
  logic                 c_vld_r;

  always_comb begin
    ax_nxt = xe[EW-1] ? EW'(-xe) : EW'(xe);
    ay_nxt = ye[EW-1] ? EW'(-ye) : EW'(ye);
    az_nxt = ze[EW-1] ? EW'(-ze) : EW'(ze);

    a_flags_nxt            = '0;
    a_flags_nxt.zero_depth = (ze == '0);
    a_flags_nxt.neg_x      = xe[EW-1] ^ ze[EW-1];
    a_flags_nxt.neg_y      = ye[EW-1] ^ ze[EW-1];
    a_flags_nxt.xe_pos     = !xe[EW-1] && (xe != '0);
    a_flags_nxt.xe_neg     = xe[EW-1];
    a_flags_nxt.ye_pos     = !ye[EW-1] && (ye != '0);
    a_flags_nxt.ye_neg     = ye[EW-1];

    if (ze[EW-1:W-1] == '0 || ze[EW-1:W-1] == '1) begin
      a_depth_nxt = ze[W-1:0];
    end else begin
      a_depth_nxt = ze[EW-1] ? MIN_W : MAX_W;
    end

    plo_x_nxt = LW'(ax_r[LO-1:0]) * LW'(h);
    plo_y_nxt = LW'(ay_r[LO-1:0]) * LW'(h);
    phi_x_nxt = HW'(ax_r[EW-1:LO]) * HW'(h);
    phi_y_nxt = HW'(ay_r[EW-1:LO]) * HW'(h);

    nx_nxt = (NW'(phi_x_r) << LO) + NW'(plo_x_r);
    ny_nxt = (NW'(phi_y_r) << LO) + NW'(plo_y_r);

    // quotient needs more than W bits when num >= den * 2^W
    c_flags_nxt       = b_flags_r;
    c_flags_nxt.ovf_x = (nx_nxt[NW-1:W] >= b_az_r);
    c_flags_nxt.ovf_y = (ny_nxt[NW-1:W] >= b_az_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r      <= ax_nxt;
      ay_r      <= ay_nxt;
      az_r      <= az_nxt;
      a_flags_r <= a_flags_nxt;
      a_depth_r <= a_depth_nxt;

      plo_x_r   <= plo_x_nxt;
      plo_y_r   <= plo_y_nxt;
      phi_x_r   <= phi_x_nxt;
      phi_y_r   <= phi_y_nxt;
      b_az_r    <= az_r;
      b_flags_r <= a_flags_r;
      b_depth_r <= a_depth_r;

      nx_r      <= nx_nxt;
      ny_r      <= ny_nxt;
      c_az_r    <= b_az_r;
      c_flags_r <= c_flags_nxt;
      c_depth_r <= b_depth_r;
    end
  end

  assign out_valid = c_vld_r;
  assign out_flags = c_flags_r;
  assign num_x     = nx_r;
  assign num_y     = ny_r;
  assign den       = c_az_r;
  assign depth     = c_depth_r;

endmodule

[hw/rtl/vvp_div_stage.sv]
// One restoring-divider stage for the x and y quotients, DIV_STEPS bits per stage.
`timescale 1ns / 1ps

module vvp_div_stage #(
  parameter int COORD_WIDTH = 24,
  parameter int QUOT_BITS   = 24
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         en,
  input  logic                                         in_valid,
  input  logic [COORD_WIDTH+vvp_pkg::EYE_EXTRA-1:0]    in_rem_x,
  input  logic [QUOT_BITS-1:0]                         in_q_x,
  input  logic [COORD_WIDTH+vvp_pkg::EYE_EXTRA-1:0]    in_rem_y,
  input  logic [QUOT_BITS-1:0]                         in_q_y,
  input  logic [COORD_WIDTH+vvp_pkg::EYE_EXTRA-1:0]    in_den,
  input  vvp_pkg::vvp_flags_t                          in_flags,
  input  logic [COORD_WIDTH-1:0]                       in_depth,
  output logic                                         out_valid,
  output logic [COORD_WIDTH+vvp_pkg::EYE_EXTRA-1:0]    out_rem_x,
  output logic [QUOT_BITS-1:0]                         out_q_x,
  output logic [COORD_WIDTH+vvp_pkg::EYE_EXTRA-1:0]    out_rem_y,
  output logic [QUOT_BITS-1:0]                         out_q_y,
  output logic [COORD_WIDTH+vvp_pkg::EYE_EXTRA-1:0]    out_den,
  output vvp_pkg::vvp_flags_t                          out_flags,
  output logic [COORD_WIDTH-1:0]                       out_depth
);

  localparam int EW = COORD_WIDTH + vvp_pkg::EYE_EXTRA;
  localparam int QB = QUOT_BITS;

  logic [EW-1:0]        rx, ry;
  logic [QB-1:0]        qx, qy;
  logic [EW:0]          tx, ty;
  logic [EW:0]          dext;
  logic                 gx, gy;

  logic [EW-1:0]        rem_x_r, rem_y_r, den_r;
  logic [QB-1:0]        q_x_r, q_y_r;
  vvp_pkg::vvp_flags_t  flags_r;
  logic [COORD_WIDTH-1:0] depth_r;
  logic                 vld_r;

  // q holds the numerator bits still to shift in; quotient bits enter at the bottom
  always_comb begin
    rx   = in_rem_x;
    ry   = in_rem_y;
    qx   = in_q_x;
    qy   = in_q_y;
    dext = {1'b0, in_den};
    tx   = '0;
    ty   = '0;
    gx   = 1'b0;
    gy   = 1'b0;
    for (int s = 0; s < vvp_pkg::DIV_STEPS; s++) begin
      tx = {rx, qx[QB-1]};
      ty = {ry, qy[QB-1]};
      gx = (tx >= dext);
      gy = (ty >= dext);
      rx = gx ? EW'(tx - dext) : tx[EW-1:0];
      ry = gy ? EW'(ty - dext) : ty[EW-1:0];
      qx = {qx[QB-2:0], gx};
      qy = {qy[QB-2:0], gy};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_x_r <= rx;
      rem_y_r <= ry;
      q_x_r   <= qx;
      q_y_r   <= qy;
      den_r   <= in_den;
      flags_r <= in_flags;
      depth_r <= in_depth;
    end
  end

  assign out_valid = vld_r;
  assign out_rem_x = rem_x_r;
  assign out_q_x   = q_x_r;
  assign out_rem_y = rem_y_r;
  assign out_q_y   = q_y_r;
  assign out_den   = den_r;
  assign out_flags = flags_r;
  assign out_depth = depth_r;

endmodule

[hw/rtl/vertex_view_perspective_projection.sv]
// Top level: config registers, projection pipeline and two-entry output buffer.
`timescale 1ns / 1ps

// Vertex view transform and perspective projection.
// Input stream: one scene vertex per transaction on in_tvalid/in_tready/in_tdata.
// Output stream: one projected vertex per input on out_tvalid/out_tready/out_tdata,
// with the zero-depth flag on out_tuser; results leave in input order.
// Config: cfg_we writes cfg_wdata to register cfg_index in the same cycle; only
// write while no vertex is in flight. Unknown indexes are ignored.
// Pipeline: 3 stages of offset/rotate/round, 3 stages of magnitude, split multiply
// and range check, ceil(COORD_WIDTH/2) divider stages (two quotient bits each),
// then the output register. A new vertex is taken every cycle while the skid
// entry is empty.
// Stall: a full output register plus one skid entry absorb a stalled receiver;
// once the skid entry is occupied the whole pipeline freezes and in_tready drops.
// in_tready comes straight from a flop, so there is no path from out_tready.
// Reset (rst_n low, synchronous) empties the pipeline and output buffer and loads
// the identity rotation, eye at origin and projection distance 1.0.

module vertex_view_perspective_projection #(
  parameter int COORD_WIDTH     = 24,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // config write port
  input  logic                                   cfg_we,
  input  logic [vvp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [vvp_pkg::ROW_W-1:0]              cfg_wdata,
  // input stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // tdata, low to high: point_x, point_y, point_z, zero pad
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  // output stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // tdata, low to high: proj_x, proj_y, eye_depth, zero pad
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]     out_tdata,
  // tuser: zero_depth
  output logic [0:0]                             out_tuser
);

  localparam int W   = COORD_WIDTH;
  localparam int EW  = W + vvp_pkg::EYE_EXTRA;
  localparam int NW  = EW + W;
  localparam int DS  = vvp_pkg::DIV_STEPS;
  localparam int NST = (W + DS - 1) / DS;
  localparam int QB  = NST * DS;
  localparam int TW  = ((3*COORD_WIDTH+7)/8)*8;
  localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [vvp_pkg::ROW_W-1:0] rot_row_x_r, rot_row_y_r, rot_row_z_r;
  logic signed [W-1:0]       eye_pos_x_r, eye_pos_y_r, eye_pos_z_r;
  logic [W-1:0]              proj_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_row_x_r <= vvp_pkg::ROT_RESET_X;
      rot_row_y_r <= vvp_pkg::ROT_RESET_Y;
      rot_row_z_r <= vvp_pkg::ROT_RESET_Z;
      eye_pos_x_r <= '0;
      eye_pos_y_r <= '0;
      eye_pos_z_r <= '0;
      proj_dist_r <= W'(1 << COORD_FRAC_BITS);
    end else if (cfg_we) begin
      case (vvp_pkg::vvp_cfg_idx_t'(cfg_index))
        vvp_pkg::CFG_ROT_ROW_X: rot_row_x_r <= cfg_wdata;
        vvp_pkg::CFG_ROT_ROW_Y: rot_row_y_r <= cfg_wdata;
        vvp_pkg::CFG_ROT_ROW_Z: rot_row_z_r <= cfg_wdata;
        vvp_pkg::CFG_EYE_POS_X: eye_pos_x_r <= cfg_wdata[W-1:0];
        vvp_pkg::CFG_EYE_POS_Y: eye_pos_y_r <= cfg_wdata[W-1:0];
        vvp_pkg::CFG_EYE_POS_Z: eye_pos_z_r <= cfg_wdata[W-1:0];
        vvp_pkg::CFG_PROJ_DIST: proj_dist_r <= cfg_wdata[W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline enable: the whole pipe moves unless the skid entry is holding data
  // ---------------------------------------------------------------------------
  logic pipe_en;
  logic skid_valid_r;

  assign pipe_en   = !skid_valid_r;
  assign in_tready = pipe_en;

  // ---------------------------------------------------------------------------
  // Eye-space transform
  // ---------------------------------------------------------------------------
  logic                 xf_valid;
  logic signed [EW-1:0] xe, ye, ze;

  vvp_eye_xform #(
    .COORD_WIDTH(W)
  ) u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_valid (in_tvalid),
    .pt_x     (in_tdata[W-1:0]),
    .pt_y     (in_tdata[2*W-1:W]),
    .pt_z     (in_tdata[3*W-1:2*W]),
    .eye_x    (eye_pos_x_r),
    .eye_y    (eye_pos_y_r),
    .eye_z    (eye_pos_z_r),
    .row_x    (rot_row_x_r),
    .row_y    (rot_row_y_r),
    .row_z    (rot_row_z_r),
    .out_valid(xf_valid),
    .xe       (xe),
    .ye       (ye),
    .ze       (ze)
  );

  // ---------------------------------------------------------------------------
  // Numerators |e|*H and divisor |ze|
  // ---------------------------------------------------------------------------
  logic                 su_valid;
  vvp_pkg::vvp_flags_t  su_flags;
  logic [NW-1:0]        num_x, num_y;
  logic [EW-1:0]        su_den;
  logic [W-1:0]         su_depth;

  vvp_proj_setup #(
    .COORD_WIDTH(W)
  ) u_setup (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_valid (xf_valid),
    .xe       (xe),
    .ye       (ye),
    .ze       (ze),
    .h        (proj_dist_r),
    .out_valid(su_valid),
    .out_flags(su_flags),
    .num_x    (num_x),
    .num_y    (num_y),
    .den      (su_den),
    .depth    (su_depth)
  );

  // ---------------------------------------------------------------------------
  // Divider chain. Partial remainder starts at num >> QB (below den whenever the
  // quotient fits), the low QB numerator bits shift in two per stage.
  // ---------------------------------------------------------------------------
  logic                 dv_valid [NST+1];
  logic [EW-1:0]        dv_rem_x [NST+1];
  logic [EW-1:0]        dv_rem_y [NST+1];
  logic [QB-1:0]        dv_q_x   [NST+1];
  logic [QB-1:0]        dv_q_y   [NST+1];
  logic [EW-1:0]        dv_den   [NST+1];
  vvp_pkg::vvp_flags_t  dv_flags [NST+1];
  logic [W-1:0]         dv_depth [NST+1];

  assign dv_valid[0] = su_valid;
  assign dv_rem_x[0] = EW'(num_x >> QB);
  assign dv_rem_y[0] = EW'(num_y >> QB);
  assign dv_q_x[0]   = num_x[QB-1:0];
  assign dv_q_y[0]   = num_y[QB-1:0];
  assign dv_den[0]   = su_den;
  assign dv_flags[0] = su_flags;
  assign dv_depth[0] = su_depth;

  for (genvar g = 0; g < NST; g++) begin : g_div
    vvp_div_stage #(
      .COORD_WIDTH(W),
      .QUOT_BITS  (QB)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_en),
      .in_valid (dv_valid[g]),
      .in_rem_x (dv_rem_x[g]),
      .in_q_x   (dv_q_x[g]),
      .in_rem_y (dv_rem_y[g]),
      .in_q_y   (dv_q_y[g]),
      .in_den   (dv_den[g]),
      .in_flags (dv_flags[g]),
      .in_depth (dv_depth[g]),
      .out_valid(dv_valid[g+1]),
      .out_rem_x(dv_rem_x[g+1]),
      .out_q_x  (dv_q_x[g+1]),
      .out_rem_y(dv_rem_y[g+1]),
      .out_q_y  (dv_q_y[g+1]),
      .out_den  (dv_den[g+1]),
      .out_flags(dv_flags[g+1]),
      .out_depth(dv_depth[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Sign, clamp and zero-depth handling
  // ---------------------------------------------------------------------------
  function automatic logic [W-1:0] lane_result(
    input logic [QB-1:0] q,
    input logic          ovf,
    input logic          neg,
    input logic          zero,
    input logic          num_pos,
    input logic          num_neg
  );
    logic [QB-1:0] lim;
    logic [QB-1:0] mag;
    logic [W-1:0]  res;
    // negative side reaches one step further
    lim = neg ? QB'(MIN_W) : QB'(MAX_W);
    if (ovf || q > lim) begin
      mag = lim;
    end else begin
      mag = q;
    end
    res = neg ? W'(-mag) : W'(mag);
    if (zero) begin
      res = num_pos ? MAX_W : (num_neg ? MIN_W : '0);
    end
    return res;
  endfunction

  vvp_pkg::vvp_flags_t fin_flags;
  logic [W-1:0]        fin_px, fin_py;
  logic [3*W-1:0]      fin_data;
  logic                fin_valid;

  assign fin_valid = dv_valid[NST];
  assign fin_flags = dv_flags[NST];

  always_comb begin
    fin_px = lane_result(dv_q_x[NST], fin_flags.ovf_x, fin_flags.neg_x,
                         fin_flags.zero_depth, fin_flags.xe_pos, fin_flags.xe_neg);
    fin_py = lane_result(dv_q_y[NST], fin_flags.ovf_y, fin_flags.neg_y,
                         fin_flags.zero_depth, fin_flags.ye_pos, fin_flags.ye_neg);
    fin_data = {dv_depth[NST], fin_py, fin_px};
  end

  // ---------------------------------------------------------------------------
  // Output register with one skid entry
  // ---------------------------------------------------------------------------
  logic           out_valid_r;
  logic [3*W-1:0] out_data_r, skid_data_r;
  logic           out_user_r, skid_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // pipe frozen; drain skid into output when taken
      if (out_tready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (fin_valid) begin
      if (!out_valid_r || out_tready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
      end
    end else if (fin_valid) begin
      if (!out_valid_r || out_tready) begin
        out_data_r <= fin_data;
        out_user_r <= fin_flags.zero_depth;
      end else begin
        skid_data_r <= fin_data;
        skid_user_r <= fin_flags.zero_depth;
      end
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = TW'(out_data_r);
  assign out_tuser[0] = out_user_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // skid only ever holds data behind a full output register
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry occupied while output register empty");

  // skid fills only when the output was stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid entry filled without an output stall");

  // an accepted output frees the skid entry on the next edge
  assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_tready) |=> !skid_valid_r)
    else $error("skid entry not drained after output transaction");

  // a set zero-depth flag must come with a zero depth field
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r) |-> (out_data_r[3*W-1:2*W] == '0))
    else $error("zero_depth set with non-zero eye depth");

endmodule

[dv/tb_vertex_view_perspective_projection.sv]
// Self-checking testbench for the vertex view transform and perspective projection block.
`timescale 1ns / 1ps

module tb_vertex_view_perspective_projection;

  localparam int CW   = 24;                      // coordinate width
  localparam int FRAC = 8;                       // coordinate fraction bits
  localparam int DW   = ((3 * CW + 7) / 8) * 8;  // stream tdata width

  localparam longint COORD_HI = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint COORD_LO = -(longint'(1) <<< (CW - 1));
  localparam logic [CW-1:0] C_MAX = 24'h7FFFFF;
  localparam logic [CW-1:0] C_MIN = 24'h800000;

  // No register lives at this index; writes to it must leave everything alone.
  localparam logic [vvp_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 40;             // pipeline is 19 deep, leave margin
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 54;

  typedef struct {
    logic [CW-1:0] proj_x;
    logic [CW-1:0] proj_y;
    logic [CW-1:0] eye_depth;
    logic          zero_depth;
  } projected_t;

  // Holds a private copy of the register file and the queue of projected
  // vertices still owed by the block, oldest first.
  class projection_tracker;
    logic [vvp_pkg::ROW_W-1:0] rot_row[3];
    logic [CW-1:0]             eye_pos[3];
    logic [CW-1:0]             plane_dist;
    projected_t                awaited[$];
    int unsigned               mismatches;

    function new();
      rot_row    = '{vvp_pkg::ROT_RESET_X, vvp_pkg::ROT_RESET_Y, vvp_pkg::ROT_RESET_Z};
      eye_pos    = '{'0, '0, '0};
      plane_dist = CW'(1 << FRAC);
      mismatches = 0;
    endfunction

    function void write_reg(logic [vvp_pkg::CFG_IDX_W-1:0] idx,
                            logic [vvp_pkg::ROW_W-1:0] data);
      case (idx)
        vvp_pkg::CFG_ROT_ROW_X: rot_row[0] = data;
        vvp_pkg::CFG_ROT_ROW_Y: rot_row[1] = data;
        vvp_pkg::CFG_ROT_ROW_Z: rot_row[2] = data;
        vvp_pkg::CFG_EYE_POS_X: eye_pos[0] = data[CW-1:0];
        vvp_pkg::CFG_EYE_POS_Y: eye_pos[1] = data[CW-1:0];
        vvp_pkg::CFG_EYE_POS_Z: eye_pos[2] = data[CW-1:0];
        vvp_pkg::CFG_PROJ_DIST: plane_dist = data[CW-1:0];
        default: ;
      endcase
    endfunction

    // Dot product with one Q2.14 row, rounded half up (floor of value + 0.5).
    function longint eye_axis(logic [vvp_pkg::ROW_W-1:0] row, longint dx, longint dy,
                              longint dz);
      longint acc;
      acc = longint'($signed(row[15:0])) * dx + longint'($signed(row[31:16])) * dy
          + longint'($signed(row[47:32])) * dz;
      return (acc + (longint'(1) <<< (vvp_pkg::ROT_FRAC - 1))) >>> vvp_pkg::ROT_FRAC;
    endfunction

    function logic [CW-1:0] clamp(longint v);
      if (v > COORD_HI) return CW'(COORD_HI);
      if (v < COORD_LO) return CW'(COORD_LO);
      return CW'(v);
    endfunction

    // num*h/den truncated toward zero and saturated; zero den saturates by sign of num
    function logic [CW-1:0] divide_sat(longint num, longint h, longint den);
      longint q;
      if (den == 0) begin
        if (num > 0) return CW'(COORD_HI);
        if (num < 0) return CW'(COORD_LO);
        return '0;
      end
      q = ((num < 0) ? -num : num) * h / ((den < 0) ? -den : den);
      if ((num < 0) != (den < 0)) return clamp(-q);
      return clamp(q);
    endfunction

    function void note_vertex(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz);
      longint dx, dy, dz, xe, ye, ze, h;
      projected_t r;
      dx = longint'($signed(px)) - longint'($signed(eye_pos[0]));
      dy = longint'($signed(py)) - longint'($signed(eye_pos[1]));
      dz = longint'($signed(pz)) - longint'($signed(eye_pos[2]));
      xe = eye_axis(rot_row[0], dx, dy, dz);
      ye = eye_axis(rot_row[1], dx, dy, dz);
      ze = eye_axis(rot_row[2], dx, dy, dz);
      h  = plane_dist;
      r.proj_x     = divide_sat(xe, h, ze);
      r.proj_y     = divide_sat(ye, h, ze);
      r.eye_depth  = clamp(ze);
      r.zero_depth = (ze == 0);
      awaited = {awaited, r};
    endfunction

    function void compare_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_projection(logic [DW-1:0] data, logic flag);
      projected_t want;
      if (awaited.size() == 0) begin
        $error("result transaction with nothing outstanding: tdata %h", data);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("proj_x", want.proj_x, data[CW-1:0]);
      compare_field("proj_y", want.proj_y, data[2*CW-1:CW]);
      compare_field("eye_depth", want.eye_depth, data[3*CW-1:2*CW]);
      compare_field("zero_depth", CW'(want.zero_depth), CW'(flag));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [vvp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vvp_pkg::ROW_W-1:0]     cfg_wdata;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [DW-1:0]                 in_tdata;   // point_x, point_y, point_z from bit 0 up
  logic                          out_tvalid;
  logic                          out_tready;
  logic [DW-1:0]                 out_tdata;  // proj_x, proj_y, eye_depth from bit 0 up
  logic [0:0]                    out_tuser;  // zero_depth

  projection_tracker tracker;
  bit tx_gaps   = 1'b1;  // sender may insert idle bursts
  bit rx_stalls = 1'b1;  // receiver may hold off

  vertex_view_perspective_projection #(
    .COORD_WIDTH    (CW),
    .COORD_FRAC_BITS(FRAC)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered and left on a falling edge, so
  // inputs only ever move away from the sampling edge.
  // --------------------------------------------------------------------------

  // One register write; cfg_we is left high so back-to-back writes need no
  // toggle in the same step. The caller drops it after the batch.
  task automatic write_reg(logic [vvp_pkg::CFG_IDX_W-1:0] idx,
                           logic [vvp_pkg::ROW_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Offer one vertex, optionally after an idle burst, and hold it until taken.
  task automatic send_vertex(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pz, py, px};
    do @(posedge clk); while (!in_tready);
    tracker.note_vertex(px, py, pz);
    @(negedge clk);
  endtask

  // Sender holds off until every owed projection has come back; also the
  // only safe point to touch the registers.
  task automatic wait_drained();
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [vvp_pkg::ROT_COEF_W-1:0] rand_coef();
    // rotation-like magnitude, within +/-1.0
    return vvp_pkg::ROT_COEF_W'($urandom_range(0, 32768)) - 16'd16384;
  endfunction

  // Mostly near the eye so projections stay in range, some full-range noise,
  // some extremes, and now and then exactly on the eye (zero offset).
  function automatic logic [CW-1:0] pick_coord(logic [CW-1:0] eye_c);
    case ($urandom_range(0, 9))
      0:       return eye_c;
      1:       return $urandom_range(0, 1) ? C_MAX : C_MIN;
      2, 3, 4: return CW'($urandom);
      default: return eye_c + CW'($urandom_range(0, 8191)) - 24'd4096;
    endcase
  endfunction

  task automatic randomize_setup();
    vvp_pkg::vvp_cfg_idx_t     row_reg[3];
    vvp_pkg::vvp_cfg_idx_t     eye_reg[3];
    logic [vvp_pkg::ROW_W-1:0] ident[3];
    logic [vvp_pkg::ROW_W-1:0] row;
    logic [CW-1:0]             val;
    row_reg = '{vvp_pkg::CFG_ROT_ROW_X, vvp_pkg::CFG_ROT_ROW_Y, vvp_pkg::CFG_ROT_ROW_Z};
    eye_reg = '{vvp_pkg::CFG_EYE_POS_X, vvp_pkg::CFG_EYE_POS_Y, vvp_pkg::CFG_EYE_POS_Z};
    ident   = '{vvp_pkg::ROT_RESET_X, vvp_pkg::ROT_RESET_Y, vvp_pkg::ROT_RESET_Z};
    // identity rows keep zero-depth hits likely when a point sits on the eye plane
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 3))
        0:       row = ident[i];
        1:       row = vvp_pkg::ROW_W'({$urandom, $urandom});
        default: row = {rand_coef(), rand_coef(), rand_coef()};
      endcase
      write_reg(row_reg[i], row);
    end
    // upper half of wdata is junk for the 24-bit registers and must be dropped
    for (int i = 0; i < 3; i++) begin
      val = $urandom_range(0, 1) ? CW'($urandom) : CW'($urandom_range(0, 131072) - 65536);
      write_reg(eye_reg[i], {CW'($urandom), val});
    end
    case ($urandom_range(0, 5))
      0:       val = 24'd1;
      1:       val = 24'hFFFFFF;
      2:       val = 24'd256;
      3:       val = CW'($urandom);
      default: val = CW'($urandom_range(1, 4096));
    endcase
    write_reg(vvp_pkg::CFG_PROJ_DIST, {CW'($urandom), val});
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_UNMAPPED, vvp_pkg::ROW_W'({$urandom, $urandom}));
    end
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready in random runs, broken by stall bursts.
  // --------------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (rx_stalls && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  // Result transactions are checked in order against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_projection(out_tdata, out_tuser[0]);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_vertex_view_perspective_projection: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    tracker   = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset setup: identity view, eye at origin, plane at 1.0.
    send_vertex(24'd0, 24'd0, 24'd0);            // zero depth, nothing to project
    send_vertex(24'd256, -24'sd256, 24'd0);      // zero depth, x to max, y to min
    send_vertex(C_MAX, C_MIN, 24'd1);            // tiny depth, both overflow
    send_vertex(C_MIN, C_MAX, -24'sd1);          // negative depth, flipped signs
    send_vertex(24'd512, -24'sd768, 24'd256);    // plain in-range projection
    send_vertex(C_MAX, C_MAX, C_MAX);
    send_vertex(C_MIN, C_MIN, C_MIN);
    send_vertex(24'd100, -24'sd100, 24'd3);      // quotient truncates toward zero
    in_tvalid <= 1'b0;
    wait_drained();

    // Extreme coefficients, eye at the range ends so offsets exceed 24 bits,
    // widest plane distance; ze follows dx. Unmapped index written last.
    write_reg(vvp_pkg::CFG_ROT_ROW_X, {16'h7FFF, 16'h7FFF, 16'h7FFF});
    write_reg(vvp_pkg::CFG_ROT_ROW_Y, {16'h8000, 16'h8000, 16'h8000});
    write_reg(vvp_pkg::CFG_ROT_ROW_Z, vvp_pkg::ROT_RESET_X);
    write_reg(vvp_pkg::CFG_EYE_POS_X, {24'hFFFFFF, C_MIN});
    write_reg(vvp_pkg::CFG_EYE_POS_Y, {24'hA5A5A5, C_MAX});
    write_reg(vvp_pkg::CFG_EYE_POS_Z, {24'hFFFFFF, 24'h000000});
    write_reg(vvp_pkg::CFG_PROJ_DIST, {24'h5A5A5A, 24'hFFFFFF});
    write_reg(CFG_UNMAPPED, 48'hFFFF_FFFF_FFFF);
    cfg_we <= 1'b0;
    send_vertex(C_MAX, C_MIN, C_MAX);            // eye depth saturates high
    send_vertex(C_MIN, C_MAX, C_MIN);            // dx zero: zero depth
    send_vertex(C_MIN, C_MIN, C_MAX);            // zero depth, xe negative
    send_vertex(24'd1, C_MAX, C_MIN);
    send_vertex(C_MAX, C_MAX, C_MIN);
    in_tvalid <= 1'b0;
    wait_drained();

    // Rounding ties and zero plane distance: half-weight rows so +/-0.5
    // lands on the tie, a 1/16384 row that always rounds away.
    write_reg(vvp_pkg::CFG_ROT_ROW_X, 48'h0000_0000_2000);
    write_reg(vvp_pkg::CFG_ROT_ROW_Y, 48'h0000_0000_0001);
    write_reg(vvp_pkg::CFG_ROT_ROW_Z, 48'h2000_0000_0000);
    write_reg(vvp_pkg::CFG_EYE_POS_X, '0);
    write_reg(vvp_pkg::CFG_EYE_POS_Y, '0);
    write_reg(vvp_pkg::CFG_EYE_POS_Z, '0);
    write_reg(vvp_pkg::CFG_PROJ_DIST, '0);
    cfg_we <= 1'b0;
    send_vertex(24'd1, 24'd1, 24'd1);            // +0.5 rounds up, depth 1
    send_vertex(-24'sd1, -24'sd1, -24'sd1);      // -0.5 rounds to zero: zero depth
    send_vertex(24'd3, 24'd5, -24'sd3);          // -1.5 to -1, 1.5 to 2
    send_vertex(-24'sd3, 24'd0, 24'd3);
    in_tvalid <= 1'b0;
    wait_drained();

    // Random phases, each under a fresh setup. The last runs flat out with
    // no gaps or stalls.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES - 1) begin
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
      end
      randomize_setup();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 24) == 0)
          send_vertex(tracker.eye_pos[0], tracker.eye_pos[1], tracker.eye_pos[2]);
        else
          send_vertex(pick_coord(tracker.eye_pos[0]), pick_coord(tracker.eye_pos[1]),
                      pick_coord(tracker.eye_pos[2]));
      end
      in_tvalid <= 1'b0;
      wait_drained();
    end

    // Let any stray result transaction surface before the verdict.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb_vertex_view_perspective_projection: clean");
    end else begin
      $display("tb_vertex_view_perspective_projection: errors");
    end
    $finish;
  end

endmodule
